FILE: sv/wbss_pkg.sv
// Package for the wildcard byte signature scan unit.
// Holds the request/result payload types, the configuration register map
// and the shared widths; no dependencies.
package wbss_pkg;

  localparam int unsigned DataW    = 8;
  localparam int unsigned AddrW    = 48;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned PatRegs  = 4;
  localparam int unsigned SigBytes = 32;
  localparam int unsigned LenW     = 6;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_0_7   = 3'd0,
    CFG_PAT_8_15  = 3'd1,
    CFG_PAT_16_23 = 3'd2,
    CFG_PAT_24_31 = 3'd3,
    CFG_CARE_MASK = 3'd4,
    CFG_PAT_LEN   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic [AddrW-1:0] byte_address;
    logic             first_of_region;
    logic             first_of_search;
    logic             last_of_search;
  } scan_req_t;

  typedef struct packed {
    logic             found;
    logic [AddrW-1:0] match_address;
  } scan_rsp_t;

  typedef struct packed {
    logic [PatRegs-1:0][CfgDataW-1:0] pattern;
    logic [SigBytes-1:0]              care_mask;
    logic [LenW-1:0]                  pattern_length;
  } scan_cfg_t;

  typedef struct packed {
    logic      valid;
    scan_rsp_t rsp;
  } scan_res_t;

endpackage

FILE: sv/wbss_cfg_regs.sv
// Configuration register file of the signature scan unit.
// Depends on wbss_pkg for the register map and the scan_cfg_t bundle.
module wbss_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wbss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbss_pkg::CfgDataW-1:0] cfg_wdata_i,
  output wbss_pkg::scan_cfg_t           cfg_o
);

  wbss_pkg::scan_cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (wbss_pkg::cfg_idx_e'(cfg_idx_i))
        wbss_pkg::CFG_PAT_0_7:   cfg_d.pattern[0] = cfg_wdata_i;
        wbss_pkg::CFG_PAT_8_15:  cfg_d.pattern[1] = cfg_wdata_i;
        wbss_pkg::CFG_PAT_16_23: cfg_d.pattern[2] = cfg_wdata_i;
        wbss_pkg::CFG_PAT_24_31: cfg_d.pattern[3] = cfg_wdata_i;
        wbss_pkg::CFG_CARE_MASK:
          cfg_d.care_mask = cfg_wdata_i[wbss_pkg::SigBytes-1:0];
        wbss_pkg::CFG_PAT_LEN:
          cfg_d.pattern_length = cfg_wdata_i[wbss_pkg::LenW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern        <= '0;
      cfg_q.care_mask      <= '0;
      cfg_q.pattern_length <= wbss_pkg::LenW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/wbss_window.sv
// Byte window, fill count and search-done flag with the parallel
// wildcard compare. Depends on wbss_pkg for payload and config types.
module wbss_window #(
  parameter int unsigned MaxBytes = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  wbss_pkg::scan_req_t req_i,
  input  wbss_pkg::scan_cfg_t cfg_i,
  output wbss_pkg::scan_res_t res_o
);

  localparam int unsigned IdxW  = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;
  localparam int unsigned FillW = $clog2(MaxBytes + 1);
  localparam int unsigned LenW  = wbss_pkg::LenW;
  localparam int unsigned AddrW = wbss_pkg::AddrW;
  localparam int unsigned DataW = wbss_pkg::DataW;

  logic [MaxBytes-1:0][DataW-1:0] win_q, win_d;
  logic [FillW-1:0]               fill_q, fill_d, fill_base;
  logic                           done_q, done_d, done_eff;
  logic [LenW-1:0]                len_u;
  logic [wbss_pkg::PatRegs*wbss_pkg::CfgDataW-1:0] sig_flat;
  logic                           lanes_ok, match;

  assign sig_flat = cfg_i.pattern;
  assign done_eff = done_q & ~req_i.first_of_search;

  always_comb begin
    if (cfg_i.pattern_length > LenW'(MaxBytes)) begin
      len_u = LenW'(MaxBytes);
    end else begin
      len_u = cfg_i.pattern_length;
    end
  end

  always_comb begin
    fill_base = (req_i.first_of_search | req_i.first_of_region) ? '0 : fill_q;
    if (fill_base < FillW'(MaxBytes)) begin
      fill_d = fill_base + FillW'(1);
    end else begin
      fill_d = fill_base;
    end
    win_d[0] = req_i.data_byte;
    for (int k = 1; k < MaxBytes; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  always_comb begin
    logic [LenW-1:0] idx;
    lanes_ok = 1'b1;
    idx      = '0;
    for (int i = 0; i < MaxBytes; i++) begin
      idx = len_u - LenW'(i) - LenW'(1);
      if ((LenW'(i) < len_u) && cfg_i.care_mask[i] &&
          (sig_flat[8*i +: 8] != win_d[idx[IdxW-1:0]])) begin
        lanes_ok = 1'b0;
      end
    end
  end

  assign match  = (len_u != '0) && (LenW'(fill_d) >= len_u) && lanes_ok;
  assign done_d = done_eff | match | req_i.last_of_search;

  always_comb begin
    res_o.valid             = ~done_eff & (match | req_i.last_of_search);
    res_o.rsp.found         = match;
    res_o.rsp.match_address = '0;
    if (match) begin
      res_o.rsp.match_address = req_i.byte_address - AddrW'(len_u) + AddrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else if (step_i) begin
      done_q <= done_d;
      if (!done_eff) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && !done_eff) begin
      win_q <= win_d;
    end
  end

`ifndef SYNTHESIS
  a_result_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid |=> done_q)
    else $error("search not closed after a result");

  a_done_is_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && !req_i.first_of_search |-> !res_o.valid)
    else $error("result given after the search finished");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(MaxBytes))
    else $error("window fill beyond depth");

  a_short_fill_no_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && req_i.first_of_region && (len_u > LenW'(1)) |-> !match)
    else $error("match spans a region start");
`endif

endmodule

FILE: sv/wildcard_byte_signature_scan_unit.sv
// Top level of the wildcard byte signature scan unit.
// Depends on wbss_pkg, wbss_cfg_regs and wbss_window.
//
// Requests (one memory byte with its address and search/region flags)
// enter on the in_valid_i/in_ready_o channel; results leave on the
// out_valid_o/out_ready_i channel. A request is held in an input register,
// matched against the byte window, and any result lands in the output
// register, which drives out_valid_o. One request per cycle is taken while
// the receiver does not stall; the single window compare stage sets it.
// A request causes at most one result: found with the start address of
// the match, or not-found on the last byte of a search without a match.
// After a result, bytes are dropped until a request opens a new search.
// When the receiver stalls, the result register holds and the input
// register fills; in_ready_o falls only while both are occupied.
// Reset empties both registers, the window fill count and the done flag, and
// loads the configuration defaults (pattern length one, all bytes wildcard).
// Configuration writes via cfg_we_i take effect on the next cycle.
module wildcard_byte_signature_scan_unit #(
  parameter int unsigned MAX_PATTERN_BYTES = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wbss_pkg::scan_req_t           in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wbss_pkg::scan_rsp_t           out_result_o,
  input  logic                          cfg_we_i,
  input  logic [wbss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbss_pkg::CfgDataW-1:0] cfg_wdata_i
);

  wbss_pkg::scan_cfg_t cfg;
  wbss_pkg::scan_req_t req_q;
  wbss_pkg::scan_rsp_t rsp_q;
  wbss_pkg::scan_res_t res;
  logic                req_valid_q, req_valid_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic                advance;

  wbss_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  wbss_window #(
    .MaxBytes (MAX_PATTERN_BYTES)
  ) u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .req_i  (req_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign advance    = req_valid_q & (~rsp_valid_q | out_ready_i);
  assign in_ready_o = ~req_valid_q | advance;

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_ready_o) begin
      req_valid_d = in_valid_i;
    end
    rsp_valid_d = rsp_valid_q & ~out_ready_i;
    if (advance) begin
      rsp_valid_d = res.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (advance && res.valid) begin
      rsp_q <= res.rsp;
    end
  end

  assign out_valid_o  = rsp_valid_q;
  assign out_result_o = rsp_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !advance)
    else $error("result register overwritten while stalled");

  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_result_o.found |-> out_result_o.match_address == '0)
    else $error("not-found result with nonzero address");

  a_pipe_full_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !advance |-> !in_ready_o)
    else $error("input register overwritten while held");
`endif

endmodule

FILE: tb/wbss_scan_checker.sv
// Checker for the wildcard byte signature scan unit: tracks register writes,
// predicts the scan result of every accepted request and compares results.
// Depends on wbss_pkg for the payload, configuration and register index types.
`timescale 1ns / 1ps

module wbss_scan_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic                          req_ready_i,
  input  wbss_pkg::scan_req_t           req_i,
  input  logic                          rsp_valid_i,
  input  logic                          rsp_ready_i,
  input  wbss_pkg::scan_rsp_t           rsp_i,
  input  logic                          cfg_we_i,
  input  logic [wbss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wbss_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o,
  output int unsigned                   results_o,
  output int unsigned                   hits_o
);

  wbss_pkg::scan_cfg_t shadow_cfg;
  logic [7:0]          window [wbss_pkg::SigBytes];
  int unsigned         window_fill;
  bit                  search_closed;
  wbss_pkg::scan_rsp_t results_due [$];
  int unsigned         fails;
  int unsigned         results;
  int unsigned         hits;

  task automatic flag_mismatch(input string what,
                               input logic [wbss_pkg::AddrW-1:0] got,
                               input logic [wbss_pkg::AddrW-1:0] want);
    $display("[%0t] mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fails++;
  endtask

  task automatic scan_byte(input wbss_pkg::scan_req_t r);
    int unsigned         n;
    bit                  hit;
    wbss_pkg::scan_rsp_t due;
    n = shadow_cfg.pattern_length;
    if (n > wbss_pkg::SigBytes) n = wbss_pkg::SigBytes;
    if (r.first_of_search) begin
      search_closed = 1'b0;
      window_fill   = 0;
    end
    if (search_closed) return;
    if (r.first_of_region) window_fill = 0;
    for (int k = wbss_pkg::SigBytes - 1; k > 0; k--) window[k] = window[k-1];
    window[0] = r.data_byte;
    if (window_fill < wbss_pkg::SigBytes) window_fill++;
    hit = (n != 0) && (window_fill >= n);
    for (int unsigned i = 0; i < n && hit; i++) begin
      if (shadow_cfg.care_mask[i] &&
          shadow_cfg.pattern[i>>3][8*(i&7) +: 8] != window[n-1-i]) hit = 1'b0;
    end
    if (hit) begin
      search_closed       = 1'b1;
      due.found           = 1'b1;
      due.match_address   = r.byte_address - wbss_pkg::AddrW'(n - 1);
      results_due.push_back(due);
    end else if (r.last_of_search) begin
      search_closed       = 1'b1;
      due.found           = 1'b0;
      due.match_address   = '0;
      results_due.push_back(due);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    wbss_pkg::scan_rsp_t due;
    if (!rst_ni) begin
      shadow_cfg                = '0;
      shadow_cfg.pattern_length = wbss_pkg::LenW'(1);
      for (int k = 0; k < wbss_pkg::SigBytes; k++) window[k] = '0;
      window_fill   = 0;
      search_closed = 1'b0;
      results_due.delete();
      fails   = 0;
      results = 0;
      hits    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wbss_pkg::CFG_PAT_0_7:   shadow_cfg.pattern[0] = cfg_wdata_i;
          wbss_pkg::CFG_PAT_8_15:  shadow_cfg.pattern[1] = cfg_wdata_i;
          wbss_pkg::CFG_PAT_16_23: shadow_cfg.pattern[2] = cfg_wdata_i;
          wbss_pkg::CFG_PAT_24_31: shadow_cfg.pattern[3] = cfg_wdata_i;
          wbss_pkg::CFG_CARE_MASK:
            shadow_cfg.care_mask = cfg_wdata_i[wbss_pkg::SigBytes-1:0];
          wbss_pkg::CFG_PAT_LEN:
            shadow_cfg.pattern_length = cfg_wdata_i[wbss_pkg::LenW-1:0];
          default: ;
        endcase
      end
      if (rsp_valid_i && rsp_ready_i) begin
        results++;
        if (rsp_i.found) hits++;
        if (results_due.size() == 0) begin
          flag_mismatch("result with no request pending", rsp_i.match_address, '0);
        end else begin
          due = results_due.pop_front();
          if (rsp_i.found !== due.found)
            flag_mismatch("found", wbss_pkg::AddrW'(rsp_i.found),
                          wbss_pkg::AddrW'(due.found));
          if (rsp_i.match_address !== due.match_address)
            flag_mismatch("match_address", rsp_i.match_address, due.match_address);
        end
      end
      if (req_valid_i && req_ready_i) scan_byte(req_i);
    end
    fail_count_o <= fails;
    pending_o    <= results_due.size();
    results_o    <= results;
    hits_o       <= hits;
  end

endmodule

FILE: tb/testbench.sv
// Testbench top for the wildcard byte signature scan unit: clock, reset,
// register programming and byte stream stimulus, final verdict.
// Depends on wbss_pkg, wildcard_byte_signature_scan_unit and wbss_scan_checker.
`timescale 1ns / 1ps

module testbench;

  localparam logic [wbss_pkg::CfgIdxW-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [wbss_pkg::CfgIdxW-1:0] CFG_UNMAPPED_HI = 3'd7;
  localparam int unsigned                  ByteTarget      = 1600;
  localparam int unsigned                  NoEmbed         = 1 << 20;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  wbss_pkg::scan_req_t           in_req_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  wbss_pkg::scan_rsp_t           out_result_o;
  logic                          cfg_we_i;
  logic [wbss_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [wbss_pkg::CfgDataW-1:0] cfg_wdata_i;

  int unsigned         fails;
  int unsigned         pending;
  int unsigned         results;
  int unsigned         hits;
  int unsigned         bytes_sent;
  int unsigned         settings_used;
  bit                  quiet;
  wbss_pkg::scan_cfg_t cur_cfg;

  wildcard_byte_signature_scan_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_result_o(out_result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  wbss_scan_checker checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_i (in_ready_o),
    .req_i       (in_req_i),
    .rsp_valid_i (out_valid_o),
    .rsp_ready_i (out_ready_i),
    .rsp_i       (out_result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count_o(fails),
    .pending_o   (pending),
    .results_o   (results),
    .hits_o      (hits)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("run timed out with %0d results outstanding", pending);
    $display("FAIL");
    $finish;
  end

  initial begin
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  function automatic wbss_pkg::scan_req_t mk_req(input logic [7:0] data,
                                                 input logic [wbss_pkg::AddrW-1:0] addr,
                                                 input bit region, input bit start,
                                                 input bit last);
    wbss_pkg::scan_req_t r;
    r.data_byte       = data;
    r.byte_address    = addr;
    r.first_of_region = region;
    r.first_of_search = start;
    r.last_of_search  = last;
    return r;
  endfunction

  function automatic int unsigned used_len(input wbss_pkg::scan_cfg_t c);
    return (c.pattern_length > wbss_pkg::SigBytes) ? wbss_pkg::SigBytes : c.pattern_length;
  endfunction

  function automatic logic [7:0] sig_byte(input wbss_pkg::scan_cfg_t c,
                                          input int unsigned i);
    return c.pattern[i>>3][8*(i&7) +: 8];
  endfunction

  function automatic logic [wbss_pkg::AddrW-1:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return {wbss_pkg::AddrW{1'b1}} - wbss_pkg::AddrW'($urandom_range(0, 40));
      1:       return wbss_pkg::AddrW'($urandom_range(0, 40));
      default: return wbss_pkg::AddrW'({$urandom, $urandom});
    endcase
  endfunction

  function automatic int unsigned pick_region(input int unsigned remaining);
    return ($urandom_range(0, 1) == 0) ? remaining : $urandom_range(1, remaining);
  endfunction

  function automatic int unsigned pick_embed(input int unsigned region_len,
                                             input int unsigned len);
    if (len == 0 || $urandom_range(0, 2) == 0) return NoEmbed;
    return $urandom_range(0, region_len);
  endfunction

  function automatic wbss_pkg::scan_cfg_t random_cfg();
    wbss_pkg::scan_cfg_t c;
    for (int i = 0; i < wbss_pkg::PatRegs; i++) begin
      case ($urandom_range(0, 5))
        0:       c.pattern[i] = '0;
        1:       c.pattern[i] = '1;
        default: c.pattern[i] = {$urandom, $urandom};
      endcase
    end
    case ($urandom_range(0, 4))
      0:       c.care_mask = '0;
      1:       c.care_mask = '1;
      2:       c.care_mask = $urandom;
      default: c.care_mask = $urandom | $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       c.pattern_length = '0;
      1:       c.pattern_length = wbss_pkg::LenW'(wbss_pkg::SigBytes);
      2:       c.pattern_length = wbss_pkg::LenW'($urandom_range(wbss_pkg::SigBytes + 1, 63));
      3:       c.pattern_length = wbss_pkg::LenW'(1);
      4:       c.pattern_length = wbss_pkg::LenW'($urandom_range(9, wbss_pkg::SigBytes - 1));
      default: c.pattern_length = wbss_pkg::LenW'($urandom_range(1, 8));
    endcase
    return c;
  endfunction

  task automatic send_req(input wbss_pkg::scan_req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic drain_scanner();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put_cfg(input logic [wbss_pkg::CfgIdxW-1:0] idx,
                         input logic [wbss_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic program_cfg(input wbss_pkg::scan_cfg_t c);
    drain_scanner();
    put_cfg(wbss_pkg::CFG_PAT_0_7, c.pattern[0]);
    put_cfg(wbss_pkg::CFG_PAT_8_15, c.pattern[1]);
    put_cfg(wbss_pkg::CFG_PAT_16_23, c.pattern[2]);
    put_cfg(wbss_pkg::CFG_PAT_24_31, c.pattern[3]);
    put_cfg(wbss_pkg::CFG_CARE_MASK, {$urandom, c.care_mask});
    put_cfg(wbss_pkg::CFG_PAT_LEN, {$urandom, 26'($urandom), c.pattern_length});
    put_cfg($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    cur_cfg = c;
    settings_used++;
  endtask

  task automatic scan_search(input int unsigned n_bytes);
    wbss_pkg::scan_req_t          r;
    logic [wbss_pkg::AddrW-1:0]   addr;
    int unsigned                  len;
    int unsigned                  pos;
    int unsigned                  region_len;
    int unsigned                  embed_at;
    len        = used_len(cur_cfg);
    addr       = pick_addr();
    pos        = 0;
    region_len = pick_region(n_bytes);
    embed_at   = pick_embed(region_len, len);
    for (int unsigned j = 0; j < n_bytes; j++) begin
      if (pos == region_len) begin
        addr       = pick_addr();
        pos        = 0;
        region_len = pick_region(n_bytes - j);
        embed_at   = pick_embed(region_len, len);
      end
      r.first_of_region = (pos == 0) && !(j == 0 && $urandom_range(0, 3) == 0);
      r.first_of_search = (j == 0);
      r.last_of_search  = (j == n_bytes - 1) && ($urandom_range(0, 7) != 0);
      r.byte_address    = addr;
      if (pos >= embed_at && pos < embed_at + len && $urandom_range(0, 39) != 0)
        r.data_byte = cur_cfg.care_mask[pos - embed_at] ? sig_byte(cur_cfg, pos - embed_at)
                                                        : 8'($urandom);
      else if (len != 0 && $urandom_range(0, 1) == 0)
        r.data_byte = sig_byte(cur_cfg, $urandom_range(0, len - 1));
      else
        r.data_byte = 8'($urandom);
      send_req(r);
      addr = ($urandom_range(0, 19) == 0) ? addr + wbss_pkg::AddrW'($urandom)
                                          : addr + 1'b1;
      pos++;
    end
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) begin
      send_req(mk_req(8'($urandom), wbss_pkg::AddrW'({$urandom, $urandom}),
                      $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
                      $urandom_range(0, 3) == 0));
    end
  endtask

  initial begin
    wbss_pkg::scan_cfg_t c;
    int unsigned         len;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_req_i      = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = wbss_pkg::CFG_PAT_0_7;
    cfg_wdata_i   = '0;
    quiet         = 1'b0;
    bytes_sent    = 0;
    settings_used = 0;
    cur_cfg                = '0;
    cur_cfg.pattern_length = wbss_pkg::LenW'(1);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset defaults: one wildcard byte, then a finished search
    send_req(mk_req(8'hFF, '1, 1'b1, 1'b1, 1'b1));
    send_req(mk_req(8'h00, '0, 1'b0, 1'b0, 1'b0));
    send_req(mk_req(8'h5A, 48'h10, 1'b1, 1'b1, 1'b0));

    c = '0;
    c.care_mask = '1;
    program_cfg(c);
    send_req(mk_req(8'h00, '0, 1'b1, 1'b1, 1'b0));
    send_req(mk_req(8'h00, 48'h1, 1'b0, 1'b0, 1'b1));

    c = '0;
    c.pattern[0]      = 64'hCDAB;
    c.care_mask       = 32'h3;
    c.pattern_length  = wbss_pkg::LenW'(2);
    program_cfg(c);
    send_req(mk_req(8'hAB, 48'd100, 1'b1, 1'b1, 1'b0));
    send_req(mk_req(8'hCD, 48'd101, 1'b1, 1'b0, 1'b0));
    send_req(mk_req(8'hAB, 48'd102, 1'b0, 1'b0, 1'b0));
    send_req(mk_req(8'hCD, 48'd200, 1'b0, 1'b0, 1'b0));
    send_req(mk_req(8'hAB, 48'd0, 1'b0, 1'b0, 1'b1));
    send_req(mk_req(8'hAB, '1, 1'b1, 1'b1, 1'b0));
    send_req(mk_req(8'hCD, '0, 1'b0, 1'b0, 1'b1));
    send_req(mk_req(8'hAB, 48'd5, 1'b1, 1'b1, 1'b0));
    send_req(mk_req(8'h00, 48'd6, 1'b0, 1'b0, 1'b1));

    c = '0;
    c.pattern        = '1;
    c.care_mask      = '1;
    c.pattern_length = '1;
    program_cfg(c);
    send_req(mk_req(8'hFF, 48'h7FFF_FFFF_FFFF, 1'b1, 1'b1, 1'b0));
    send_req(mk_req(8'hFF, 48'h8000_0000_0000, 1'b0, 1'b0, 1'b1));

    while (bytes_sent < ByteTarget) begin
      quiet = (bytes_sent >= ByteTarget - ByteTarget / 6) || ($urandom_range(0, 3) == 0);
      program_cfg(random_cfg());
      len = used_len(cur_cfg);
      repeat ($urandom_range(2, 6)) begin
        if (bytes_sent >= ByteTarget) break;
        if ($urandom_range(0, 7) == 0) send_noise($urandom_range(1, 6));
        else scan_search($urandom_range(1, 2 * len + 8));
      end
    end

    drain_scanner();
    repeat (4) @(posedge clk_i);
    $display("covered %0d requests over %0d register settings", bytes_sent, settings_used);
    $display("checked %0d results, %0d of them matches", results, hits);
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
